FILE: hdl/bqvm_pkg.sv
// ----------------------------------------------------------------------------
// bqvm_pkg
// Shared types, constants and helpers for the biquad filter with volume and
// mix: register indexes, multiplier operand selects and controller commands.
// ----------------------------------------------------------------------------
package bqvm_pkg;

   localparam int COEF_BITS      = 32;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int HIST_OUT_BITS  = 32;
   localparam int ACC_BITS       = 64;
   localparam int MUL_A_BITS     = COEF_BITS + 1;
   localparam int MUL_B_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_B0     = 3'd0,
      CSR_COEF_B1_FF  = 3'd1,
      CSR_COEF_B2_FF  = 3'd2,
      CSR_COEF_FB1    = 3'd3,
      CSR_COEF_FB2    = 3'd4,
      CSR_VOLUME_GAIN = 3'd5,
      CSR_MIX_GAIN    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_B0_X,
      MUL_B1_H1,
      MUL_B2_H2,
      MUL_FB1_O1,
      MUL_FB2_O2,
      MUL_Y_VOL,
      MUL_PRIOR_MIX
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        capture;
      logic        filt_load;
      logic        hist_clear;
      logic        out_load;
      logic        out_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // saturating add or subtract on the accumulator
   function automatic logic signed [ACC_BITS-1:0] sat_acc(
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b,
      input logic                       sub
   );
      logic signed [ACC_BITS:0] sum;
      logic signed [ACC_BITS-1:0] res;
      if (sub) begin
         sum = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
      end else begin
         sum = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      end
      if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
         res = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         res = sum[ACC_BITS-1:0];
      end
      return res;
   endfunction

endpackage

FILE: hdl/bqvm_ctrl.sv
// ----------------------------------------------------------------------------
// bqvm_ctrl
// Sequencer: accepts a word, steps the shared multiplier and accumulator
// through the filter and mix products or clears history, then loads a result.
// ----------------------------------------------------------------------------
module bqvm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  bqvm_pkg::dp_status_type dp_status,
   output bqvm_pkg::dp_cmd_type    dp_cmd
);
   import bqvm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   typedef enum logic [3:0] {
      STEP_B0       = 4'd0,
      STEP_B1       = 4'd1,
      STEP_B2       = 4'd2,
      STEP_FB1      = 4'd3,
      STEP_FB2      = 4'd4,
      STEP_ACC_LAST = 4'd5,
      STEP_FILT_OUT = 4'd6,
      STEP_MUL_VOL  = 4'd7,
      STEP_MUL_MIX  = 4'd8,
      STEP_MIX_ADD  = 4'd9,
      STEP_OUT      = 4'd10
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dp_cmd   = '0;
      dp_cmd.mul_sel = MUL_B0_X;
      dp_cmd.acc_op  = ACC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.capture = 1'b1;
               step_in  = STEP_B0;
               state_in = req_action ? ST_CLEAR : ST_CALC;
            end
         end
         ST_CALC: begin
            // product of step n is accumulated in step n+1
            unique case (step_ff)
               STEP_B0: begin
                  dp_cmd.mul_sel = MUL_B0_X;
                  step_in = STEP_B1;
               end
               STEP_B1: begin
                  dp_cmd.mul_sel = MUL_B1_H1;
                  dp_cmd.acc_op  = ACC_LOAD;
                  step_in = STEP_B2;
               end
               STEP_B2: begin
                  dp_cmd.mul_sel = MUL_B2_H2;
                  dp_cmd.acc_op  = ACC_ADD;
                  step_in = STEP_FB1;
               end
               STEP_FB1: begin
                  dp_cmd.mul_sel = MUL_FB1_O1;
                  dp_cmd.acc_op  = ACC_ADD;
                  step_in = STEP_FB2;
               end
               STEP_FB2: begin
                  dp_cmd.mul_sel = MUL_FB2_O2;
                  dp_cmd.acc_op  = ACC_SUB;
                  step_in = STEP_ACC_LAST;
               end
               STEP_ACC_LAST: begin
                  dp_cmd.acc_op = ACC_SUB;
                  step_in = STEP_FILT_OUT;
               end
               STEP_FILT_OUT: begin
                  dp_cmd.filt_load = 1'b1;
                  step_in = STEP_MUL_VOL;
               end
               STEP_MUL_VOL: begin
                  dp_cmd.mul_sel = MUL_Y_VOL;
                  step_in = STEP_MUL_MIX;
               end
               STEP_MUL_MIX: begin
                  dp_cmd.mul_sel = MUL_PRIOR_MIX;
                  dp_cmd.acc_op  = ACC_LOAD;
                  step_in = STEP_MIX_ADD;
               end
               STEP_MIX_ADD: begin
                  dp_cmd.acc_op = ACC_ADD;
                  step_in = STEP_OUT;
               end
               STEP_OUT: begin
                  if (dp_status.out_free) begin
                     dp_cmd.out_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CLEAR: begin
            if (dp_status.out_free) begin
               dp_cmd.hist_clear = 1'b1;
               dp_cmd.out_load   = 1'b1;
               dp_cmd.out_zero   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_B0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: hdl/bqvm_datapath.sv
// ----------------------------------------------------------------------------
// bqvm_datapath
// Coefficient and gain registers, filter history, one shared signed
// multiplier with product register, saturating accumulator and result word.
// ----------------------------------------------------------------------------
module bqvm_datapath #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [bqvm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bqvm_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]          req_source_sample,
   input  logic signed [SAMPLE_BITS-1:0]          req_prior_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_out_sample,
   input  bqvm_pkg::dp_cmd_type                   dp_cmd,
   output bqvm_pkg::dp_status_type                dp_status
);
   import bqvm_pkg::*;

   localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;

   // configuration
   logic signed [COEF_BITS-1:0] coef_b0_ff, coef_b1_ff_ff, coef_b2_ff_ff;
   logic signed [COEF_BITS-1:0] coef_fb1_ff, coef_fb2_ff;
   logic        [GAIN_BITS-1:0] volume_gain_ff;
   logic signed [GAIN_BITS-1:0] mix_gain_ff;

   // sample and history
   logic signed [SAMPLE_BITS-1:0]   x_ff, prior_ff;
   logic signed [SAMPLE_BITS-1:0]   in_hist_one_ff, in_hist_two_ff;
   logic signed [HIST_OUT_BITS-1:0] out_hist_one_ff, out_hist_two_ff;

   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_full;
   logic signed [ACC_BITS-1:0]   prod_ff, acc_ff, acc_in;

   logic signed [ACC_BITS-1:0]      filt_bias, filt_round, filt_shift;
   logic signed [HIST_OUT_BITS-1:0] filt_sat;
   logic signed [ACC_BITS-1:0]      mix_bias, mix_round, mix_shift;
   logic signed [SAMPLE_BITS-1:0]   mix_sat;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff     <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
         coef_b1_ff_ff  <= '0;
         coef_b2_ff_ff  <= '0;
         coef_fb1_ff    <= '0;
         coef_fb2_ff    <= '0;
         volume_gain_ff <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
         mix_gain_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_B0:     coef_b0_ff     <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_B1_FF:  coef_b1_ff_ff  <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_B2_FF:  coef_b2_ff_ff  <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_FB1:    coef_fb1_ff    <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_FB2:    coef_fb2_ff    <= csr_wdata[COEF_BITS-1:0];
            CSR_VOLUME_GAIN: volume_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_MIX_GAIN:    mix_gain_ff    <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (dp_cmd.mul_sel)
         MUL_B0_X: begin
            mul_a = {coef_b0_ff[COEF_BITS-1], coef_b0_ff};
            mul_b = {{(MUL_B_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
         end
         MUL_B1_H1: begin
            mul_a = {coef_b1_ff_ff[COEF_BITS-1], coef_b1_ff_ff};
            mul_b = {{(MUL_B_BITS-SAMPLE_BITS){in_hist_one_ff[SAMPLE_BITS-1]}},
                     in_hist_one_ff};
         end
         MUL_B2_H2: begin
            mul_a = {coef_b2_ff_ff[COEF_BITS-1], coef_b2_ff_ff};
            mul_b = {{(MUL_B_BITS-SAMPLE_BITS){in_hist_two_ff[SAMPLE_BITS-1]}},
                     in_hist_two_ff};
         end
         MUL_FB1_O1: begin
            mul_a = {coef_fb1_ff[COEF_BITS-1], coef_fb1_ff};
            mul_b = out_hist_one_ff;
         end
         MUL_FB2_O2: begin
            mul_a = {coef_fb2_ff[COEF_BITS-1], coef_fb2_ff};
            mul_b = out_hist_two_ff;
         end
         MUL_Y_VOL: begin
            mul_a = {{(MUL_A_BITS-GAIN_BITS){1'b0}}, volume_gain_ff};
            mul_b = out_hist_one_ff;
         end
         MUL_PRIOR_MIX: begin
            mul_a = {{(MUL_A_BITS-GAIN_BITS){mix_gain_ff[GAIN_BITS-1]}}, mix_gain_ff};
            mul_b = {{(MUL_B_BITS-SAMPLE_BITS){prior_ff[SAMPLE_BITS-1]}}, prior_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   always_comb begin
      unique case (dp_cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = sat_acc(acc_ff, prod_ff, 1'b0);
         ACC_SUB:  acc_in = sat_acc(acc_ff, prod_ff, 1'b1);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[ACC_BITS-1:0];
      acc_ff  <= acc_in;
   end

   // filter output: shift toward zero, saturate to 32 bits
   assign filt_bias  = {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
   assign filt_round = acc_ff[ACC_BITS-1] ? (acc_ff + filt_bias) : acc_ff;
   assign filt_shift = filt_round >>> COEF_FRAC_BITS;

   always_comb begin
      if ((|filt_shift[ACC_BITS-1:HIST_OUT_BITS-1]) &&
          !(&filt_shift[ACC_BITS-1:HIST_OUT_BITS-1])) begin
         filt_sat = filt_shift[ACC_BITS-1] ? {1'b1, {(HIST_OUT_BITS-1){1'b0}}}
                                           : {1'b0, {(HIST_OUT_BITS-1){1'b1}}};
      end else begin
         filt_sat = filt_shift[HIST_OUT_BITS-1:0];
      end
   end

   // mixed output: shift toward zero, saturate to sample width
   assign mix_bias  = {{(ACC_BITS-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};
   assign mix_round = acc_ff[ACC_BITS-1] ? (acc_ff + mix_bias) : acc_ff;
   assign mix_shift = mix_round >>> GAIN_FRAC_BITS;

   always_comb begin
      if ((|mix_shift[ACC_BITS-1:SAMPLE_BITS-1]) &&
          !(&mix_shift[ACC_BITS-1:SAMPLE_BITS-1])) begin
         mix_sat = mix_shift[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         mix_sat = mix_shift[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         x_ff     <= req_source_sample;
         prior_ff <= req_prior_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hist_one_ff  <= '0;
         in_hist_two_ff  <= '0;
         out_hist_one_ff <= '0;
         out_hist_two_ff <= '0;
      end else if (dp_cmd.hist_clear) begin
         in_hist_one_ff  <= '0;
         in_hist_two_ff  <= '0;
         out_hist_one_ff <= '0;
         out_hist_two_ff <= '0;
      end else if (dp_cmd.filt_load) begin
         in_hist_two_ff  <= in_hist_one_ff;
         in_hist_one_ff  <= x_ff;
         out_hist_two_ff <= out_hist_one_ff;
         out_hist_one_ff <= filt_sat;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         rsp_sample_ff <= dp_cmd.out_zero ? '0 : mix_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_sample     = rsp_sample_ff;
   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hdl/biquad_filter_volume_mix.sv
// ----------------------------------------------------------------------------
// biquad_filter_volume_mix
// Direct-form-I biquad on audio samples, followed by volume gain and a mix
// of the prior buffer sample, truncated and saturated to a signed sample.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | action, source_sample, prior_sample
//   rsp     | out       | rsp_valid/stall    | out_sample
//   csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// A sample word passes seven products in turn through a single shared
// 33x32 multiplier with a registered product and a saturating accumulator;
// a clear word only clears the history and returns a zero sample.
// Reset is synchronous and restores coefficients, gains and history.
// A new word is taken while a result waits in the output register; the
// sequencer holds before loading a result only while rsp_stall is high.
// ----------------------------------------------------------------------------
module biquad_filter_volume_mix #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [SAMPLE_BITS-1:0]       req_source_sample,
   input  logic signed [SAMPLE_BITS-1:0]       req_prior_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_sample,
   input  logic                                csr_wr_en,
   input  logic [bqvm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bqvm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bqvm_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bqvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   bqvm_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_source_sample (req_source_sample),
      .req_prior_sample  (req_prior_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_sample    (rsp_out_sample),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status)
   );

`ifndef ASSERT_OFF
   // busy right after a word is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a word without going busy");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> dp_status.out_free)
      else $error("result register loaded while still held");

   // clear returns a zero sample
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.out_load && dp_cmd.out_zero) |=> (rsp_valid && (rsp_out_sample == '0)))
      else $error("clear did not return zero");

   // a loaded result is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |=> rsp_valid)
      else $error("loaded result not offered");
`endif

endmodule

FILE: verif/tb_biquad_filter_volume_mix.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_filter_volume_mix
// Self-checking bench for the biquad filter with volume and mix. A bit-exact
// predictor tracks coefficients, gains and filter history and queues one
// expected sample per accepted word; every result is compared in order.
// Directed tests cover default passthrough, gain and coefficient extremes, an
// unstable filter that saturates the accumulator and one long output hold;
// then random phases reprogram all registers, both channels idling at random.
// ----------------------------------------------------------------------------
module tb_biquad_filter_volume_mix;
   import bqvm_pkg::*;

   localparam int SMP_BITS = 16;
   localparam int FILT_FRAC_BITS = 28;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_WORDS = 195;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic [31:0] COEF_MAX = 32'h7fff_ffff;
   localparam logic [31:0] COEF_MIN = 32'h8000_0000;
   localparam longint FILT_MAX = 64'sd2147483647;
   localparam longint FILT_MIN = -64'sd2147483648;
   localparam longint SMP_MAX = 64'sd32767;
   localparam longint SMP_MIN = -64'sd32768;

   typedef enum {CFG_TYPICAL, CFG_FULL_RANGE, CFG_EXTREMES} cfg_mode_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_action = 1'b0;
   logic signed [SMP_BITS-1:0]          req_source_sample = '0;
   logic signed [SMP_BITS-1:0]          req_prior_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [SMP_BITS-1:0]          rsp_out_sample;
   logic                                csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]           csr_index = '0;
   logic [CSR_DATA_BITS-1:0]            csr_wdata = '0;

   // predictor copy of registers and history
   logic signed [31:0] cf_b0, cf_b1, cf_b2, cf_fb1, cf_fb2;
   logic        [15:0] vol_gain;
   logic signed [15:0] mix_gain_q;
   logic signed [15:0] hist_x1, hist_x2;
   logic signed [31:0] hist_y1, hist_y2;

   logic signed [SMP_BITS-1:0] expected_out_q[$];
   int  error_count = 0;
   bit  no_idle = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   biquad_filter_volume_mix #(
      .SAMPLE_BITS   (SMP_BITS),
      .COEF_FRAC_BITS(FILT_FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_source_sample(req_source_sample),
      .req_prior_sample (req_prior_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void reset_filter_model();
      cf_b0 = 32'sh1000_0000;
      cf_b1 = '0;
      cf_b2 = '0;
      cf_fb1 = '0;
      cf_fb2 = '0;
      vol_gain = 16'h1000;
      mix_gain_q = '0;
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
   endfunction

   function automatic void store_register(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
         CSR_COEF_B0:     cf_b0 = data;
         CSR_COEF_B1_FF:  cf_b1 = data;
         CSR_COEF_B2_FF:  cf_b2 = data;
         CSR_COEF_FB1:    cf_fb1 = data;
         CSR_COEF_FB2:    cf_fb2 = data;
         CSR_VOLUME_GAIN: vol_gain = data[15:0];
         CSR_MIX_GAIN:    mix_gain_q = data[15:0];
         default: ;
      endcase
   endfunction

   // overflow only when both operands share a sign the sum lacks
   function automatic longint add_clamped(longint a, longint b);
      longint r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) begin
         r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      end
      return r;
   endfunction

   function automatic longint shift_toward_zero(longint v, int amount);
      logic [63:0] mag;
      if (v >= 0) begin
         return v >>> amount;
      end
      mag = -v;
      return -longint'(mag >> amount);
   endfunction

   function automatic longint limit_range(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [SMP_BITS-1:0] predict_out_sample(
      bit clear_hist,
      logic signed [SMP_BITS-1:0] src,
      logic signed [SMP_BITS-1:0] prior
   );
      longint acc;
      longint filt;
      longint mixed;
      if (clear_hist) begin
         hist_x1 = '0;
         hist_x2 = '0;
         hist_y1 = '0;
         hist_y2 = '0;
         return '0;
      end
      acc = longint'(cf_b0) * longint'(src);
      acc = add_clamped(acc, longint'(cf_b1) * longint'(hist_x1));
      acc = add_clamped(acc, longint'(cf_b2) * longint'(hist_x2));
      acc = add_clamped(acc, -(longint'(cf_fb1) * longint'(hist_y1)));
      acc = add_clamped(acc, -(longint'(cf_fb2) * longint'(hist_y2)));
      filt = limit_range(shift_toward_zero(acc, FILT_FRAC_BITS), FILT_MIN, FILT_MAX);
      hist_x2 = hist_x1;
      hist_x1 = src;
      hist_y2 = hist_y1;
      hist_y1 = filt[31:0];
      mixed = filt * longint'(vol_gain) + longint'(prior) * longint'(mix_gain_q);
      mixed = limit_range(shift_toward_zero(mixed, GAIN_FRAC_BITS), SMP_MIN, SMP_MAX);
      return mixed[SMP_BITS-1:0];
   endfunction

   // receiver: random stalls, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 29);
      end
   end

   always @(posedge clock) begin : check_out_sample
      logic signed [SMP_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out_q.size() == 0) begin
            error_count++;
            $error("out_sample: expected none, actual %0d", rsp_out_sample);
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_out_sample !== want) begin
               error_count++;
               $error("out_sample: expected %0d, actual %0d", want, rsp_out_sample);
            end
         end
      end
   end

   task automatic send_word(
      input bit clear_hist,
      input logic signed [SMP_BITS-1:0] src,
      input logic signed [SMP_BITS-1:0] prior
   );
      while (!no_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= clear_hist;
      req_source_sample <= src;
      req_prior_sample <= prior;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
      expected_out_q.push_back(predict_out_sample(clear_hist, src, prior));
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_register(idx, data);
      csr_wr_en <= 1'b0;
   endtask

   // stop sending and wait until every queued sample has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SMP_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return '0;
         default: return SMP_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] pick_reg_value(logic [CSR_INDEX_BITS-1:0] idx,
                                                  cfg_mode_type mode);
      logic [31:0] v;
      bit          wide;
      wide = (idx <= CSR_COEF_FB2);
      case (mode)
         CFG_EXTREMES: begin
            if (wide) begin
               v = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end else if (idx == CSR_VOLUME_GAIN) begin
               v = $urandom_range(0, 1) ? 32'h0000_ffff : 32'h0;
            end else begin
               v = $urandom_range(0, 1) ? 32'h0000_7fff : 32'h0000_8000;
            end
         end
         CFG_FULL_RANGE: v = $urandom();
         default: begin
            // roughly stable filters and moderate gains
            case (idx)
               CSR_COEF_FB1:    v = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
               CSR_COEF_FB2:    v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
               CSR_VOLUME_GAIN: v = $urandom_range(0, 32'h2000);
               CSR_MIX_GAIN:    v = $urandom_range(0, 32'h2000) - 32'h1000;
               default:         v = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            endcase
         end
      endcase
      // narrow registers must ignore the upper data bits
      if (!wide) begin
         v[31:16] = 16'($urandom());
      end
      return v;
   endfunction

   task automatic test_default_passthrough();
      send_word(1'b0, 16'sh7fff, pick_sample());
      send_word(1'b0, 16'sh8000, pick_sample());
      send_word(1'b0, -16'sd1, pick_sample());
      send_word(1'b1, pick_sample(), pick_sample());
      send_word(1'b0, 16'sd1, pick_sample());
      drain_results();
   endtask

   task automatic test_gain_extremes();
      write_csr(CSR_VOLUME_GAIN, 32'ha5a5_ffff);
      write_csr(CSR_MIX_GAIN, 32'h5a5a_8000);
      write_csr(CSR_UNMAPPED, $urandom());
      send_word(1'b0, 16'sh8000, 16'sh7fff);
      drain_results();
      write_csr(CSR_VOLUME_GAIN, 32'hffff_0000);
      write_csr(CSR_MIX_GAIN, 32'h0000_7fff);
      send_word(1'b0, 16'sh7fff, 16'sh8000);
      send_word(1'b0, 16'sh0000, 16'sh7fff);
      drain_results();
   endtask

   // feedback of -8 blows up the output history until the accumulator clamps
   task automatic test_unstable_filter();
      write_csr(CSR_COEF_B0, COEF_MAX);
      write_csr(CSR_COEF_B1_FF, COEF_MAX);
      write_csr(CSR_COEF_B2_FF, COEF_MAX);
      write_csr(CSR_COEF_FB1, COEF_MIN);
      write_csr(CSR_COEF_FB2, COEF_MIN);
      write_csr(CSR_VOLUME_GAIN, 32'h0000_1000);
      write_csr(CSR_MIX_GAIN, 32'h0000_0000);
      for (int i = 0; i < 8; i++) begin
         send_word(1'b0, 16'sh7fff, pick_sample());
      end
      send_word(1'b1, pick_sample(), pick_sample());
      for (int i = 0; i < 8; i++) begin
         send_word(1'b0, 16'sh8000, pick_sample());
      end
      drain_results();
   endtask

   task automatic test_output_backpressure();
      for (int i = CSR_COEF_B0; i <= CSR_MIX_GAIN; i++) begin
         write_csr(3'(i), pick_reg_value(3'(i), CFG_TYPICAL));
      end
      hold_request <= 1'b1;
      no_idle <= 1'b1;
      for (int i = 0; i < 24; i++) begin
         send_word($urandom_range(0, 99) < 8, pick_sample(), pick_sample());
      end
      no_idle <= 1'b0;
      drain_results();
   endtask

   task automatic test_random_phases();
      cfg_mode_type mode;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         mode = cfg_mode_type'(p % 3);
         for (int i = CSR_COEF_B0; i <= CSR_MIX_GAIN; i++) begin
            write_csr(3'(i), pick_reg_value(3'(i), mode));
         end
         no_idle <= (p == 4);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word($urandom_range(0, 99) < 8, pick_sample(), pick_sample());
         end
         drain_results();
         no_idle <= 1'b0;
      end
   endtask

   initial begin
      reset_filter_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_passthrough();
      test_gain_extremes();
      test_unstable_filter();
      test_output_backpressure();
      test_random_phases();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: biquad_filter_volume_mix.f
hdl/bqvm_pkg.sv
hdl/bqvm_ctrl.sv
hdl/bqvm_datapath.sv
hdl/biquad_filter_volume_mix.sv
verif/tb_biquad_filter_volume_mix.sv
